[hdl/bper_pkg.sv]
package bper_pkg;

  localparam int unsigned NUM_PINS     = 18;
  localparam int unsigned PIN_W        = 24;
  localparam int unsigned IDX_W        = 5;
  localparam int unsigned VAL_W        = 8;
  localparam int unsigned KIND_W       = 3;
  localparam int unsigned STEP_W       = 7;
  localparam int unsigned DIR_W        = 4;
  localparam int unsigned OUT_W        = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 8;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned DEF_NUM_BUTTONS = 18;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MOUSE_STEP = CFG_IDX_W'(1);

  localparam logic              KEY_MODE_RST   = 1'b1;
  localparam logic [STEP_W-1:0] MOUSE_STEP_RST = STEP_W'(5);

  localparam int unsigned BTN_A = 4;
  localparam int unsigned BTN_Y = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_KEY    = 3'd0,
    KIND_RELX   = 3'd1,
    KIND_RELY   = 3'd2,
    KIND_RIGHT  = 3'd3,
    KIND_LEFT   = 3'd4,
    KIND_MTSYNC = 3'd5,
    KIND_SYNC   = 3'd6
  } event_kind_e;

  typedef struct packed {
    logic [NUM_PINS-1:0] diff;
    logic [NUM_PINS-1:0] now;
    logic                chg;
    logic [DIR_W-1:0]    dir;
    logic                need;
    logic                right;
    logic                left;
    logic [STEP_W-1:0]   step;
  } job_t;

  // key report order: bit positions, select/start after the shoulder keys,
  // volp ahead of volm
  function automatic logic [IDX_W-1:0] key_order(input logic [IDX_W-1:0] slot);
    logic [IDX_W-1:0] b;
    case (slot)
      5'd8:    b = 5'd10;
      5'd9:    b = 5'd11;
      5'd10:   b = 5'd12;
      5'd11:   b = 5'd13;
      5'd12:   b = 5'd8;
      5'd13:   b = 5'd9;
      5'd14:   b = 5'd14;
      5'd15:   b = 5'd16;
      5'd16:   b = 5'd15;
      5'd17:   b = 5'd17;
      default: b = slot;
    endcase
    return b;
  endfunction

endpackage

[hdl/bper_front.sv]
module bper_front #(
  parameter int unsigned NUM_BUTTONS = bper_pkg::DEF_NUM_BUTTONS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [bper_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bper_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  input  logic [bper_pkg::NUM_PINS-1:0]       in_pins_i,
  input  logic                                q_full_i,
  output logic                                in_ready_o,
  output logic                                q_push_o,
  output bper_pkg::job_t                      q_job_o
);

  localparam int unsigned N = bper_pkg::NUM_PINS;

  logic                          keypad_q, keypad_d;
  logic [bper_pkg::STEP_W-1:0]   step_q, step_d;
  logic [N-1:0]                  prev_q, prev_d;
  logic [N-1:0]                  rep_q, rep_d;
  logic                          right_q, right_d;
  logic                          left_q, left_d;

  logic [N-1:0] mask;
  logic [N-1:0] cur;
  logic         chg, mouse, r, l, need, accept;
  logic [N-1:0] diff;

  for (genvar i = 0; i < N; i++) begin : g_mask
    assign mask[i] = (i < NUM_BUTTONS);
  end

  assign cur    = ~in_pins_i & mask;
  assign chg    = cur != prev_q;
  assign mouse  = !keypad_q;
  assign diff   = (chg && keypad_q) ? (cur ^ rep_q) : '0;
  assign r      = cur[bper_pkg::BTN_A];
  assign l      = cur[bper_pkg::BTN_Y];
  assign need   = mouse && ((|cur[bper_pkg::DIR_W-1:0]) || (r != right_q) || (l != left_q));

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept && (chg || need);

  always_comb begin
    q_job_o       = '0;
    q_job_o.diff  = diff;
    q_job_o.now   = cur;
    q_job_o.chg   = chg;
    q_job_o.dir   = mouse ? cur[bper_pkg::DIR_W-1:0] : '0;
    q_job_o.need  = need;
    q_job_o.right = r;
    q_job_o.left  = l;
    q_job_o.step  = step_q;
  end

  always_comb begin
    keypad_d = keypad_q;
    step_d   = step_q;
    prev_d   = prev_q;
    rep_d    = rep_q;
    right_d  = right_q;
    left_d   = left_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        bper_pkg::REG_KEY_MODE:   keypad_d = cfg_data_i[0];
        bper_pkg::REG_MOUSE_STEP: step_d   = cfg_data_i[bper_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
    if (accept) begin
      prev_d = cur;
      rep_d  = rep_q ^ diff;
      if (mouse) begin
        right_d = r;
        left_d  = l;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keypad_q <= bper_pkg::KEY_MODE_RST;
      step_q   <= bper_pkg::MOUSE_STEP_RST;
      prev_q   <= '0;
      rep_q    <= '0;
      right_q  <= 1'b0;
      left_q   <= 1'b0;
    end else begin
      keypad_q <= keypad_d;
      step_q   <= step_d;
      prev_q   <= prev_d;
      rep_q    <= rep_d;
      right_q  <= right_d;
      left_q   <= left_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o && keypad_q |-> q_job_o.dir == '0 && !q_job_o.need)
    else $error("mouse work queued in keypad mode");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && chg && keypad_q |=> rep_q == prev_q)
    else $error("reported state out of step after keypad change");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> !q_full_i)
    else $error("push into full queue");

endmodule

[hdl/bper_queue.sv]
module bper_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bper_pkg::job_t job_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output bper_pkg::job_t job_o
);

  localparam int unsigned D   = bper_pkg::QUEUE_DEPTH;
  localparam int unsigned PW  = (D > 1) ? $clog2(D) : 1;
  localparam int unsigned CW  = $clog2(D + 1);

  bper_pkg::job_t mem_q [D];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = cnt_q == CW'(D);
  assign valid_o = cnt_q != '0;
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PW'(D - 1)) ? '0 : wr_q + PW'(1);
    if (do_pop)  rd_d = (rd_q == PW'(D - 1)) ? '0 : rd_q + PW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CW'(1);
    if (do_pop && !do_push) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(D))
    else $error("queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + CW'(1))
    else $error("queue count lost a push");

endmodule

[hdl/bper_emit.sv]
module bper_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  bper_pkg::job_t                q_job_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bper_pkg::OUT_W-1:0]    out_data_o,
  output logic [bper_pkg::KIND_W-1:0]   out_user_o,
  output logic                          out_last_o
);

  localparam int unsigned NS     = 27;
  localparam int unsigned SW     = 5;
  localparam int unsigned NK     = bper_pkg::NUM_PINS;
  localparam int unsigned VW     = bper_pkg::VAL_W;
  localparam logic [SW-1:0] SLOT_KEY_SYNC = SW'(18);
  localparam logic [SW-1:0] SLOT_UP       = SW'(19);
  localparam logic [SW-1:0] SLOT_DOWN     = SW'(20);
  localparam logic [SW-1:0] SLOT_LEFT     = SW'(21);
  localparam logic [SW-1:0] SLOT_RIGHT    = SW'(22);
  localparam logic [SW-1:0] SLOT_BTN_R    = SW'(23);
  localparam logic [SW-1:0] SLOT_BTN_L    = SW'(24);
  localparam logic [SW-1:0] SLOT_MTSYNC   = SW'(25);
  localparam logic [SW-1:0] SLOT_SYNC     = SW'(26);

  logic [NS-1:0]         pend_q, pend_d, pend_new, oh, rest;
  bper_pkg::job_t        job_q;
  logic                  valid_q, valid_d;
  logic [bper_pkg::OUT_W-1:0] data_q, data_d;
  logic [bper_pkg::KIND_W-1:0] user_q, user_d;
  logic                  last_q, last_d;

  logic                  busy, adv, load;
  logic [SW-1:0]         sel;
  bper_pkg::event_kind_e kind;
  logic [bper_pkg::IDX_W-1:0] idx;
  logic [VW-1:0]         val, pos, neg;

  always_comb begin
    pend_new = '0;
    for (int s = 0; s < NK; s++) begin
      pend_new[s] = q_job_i.diff[bper_pkg::key_order(SW'(s))];
    end
    pend_new[SLOT_KEY_SYNC] = q_job_i.chg;
    pend_new[SLOT_UP]       = q_job_i.dir[0];
    pend_new[SLOT_DOWN]     = q_job_i.dir[1];
    pend_new[SLOT_LEFT]     = q_job_i.dir[2];
    pend_new[SLOT_RIGHT]    = q_job_i.dir[3];
    pend_new[SLOT_BTN_R]    = q_job_i.need;
    pend_new[SLOT_BTN_L]    = q_job_i.need;
    pend_new[SLOT_MTSYNC]   = q_job_i.need;
    pend_new[SLOT_SYNC]     = q_job_i.need;
  end

  assign oh   = pend_q & (~pend_q + NS'(1));
  assign rest = pend_q & ~oh;

  always_comb begin
    sel = '0;
    for (int i = 0; i < NS; i++) begin
      if (oh[i]) sel = sel | SW'(i);
    end
  end

  assign pos = {1'b0, job_q.step};
  assign neg = VW'(0) - pos;

  always_comb begin
    kind = bper_pkg::KIND_SYNC;
    idx  = '0;
    val  = '0;
    case (sel) inside
      [SW'(0):SW'(NK - 1)]: begin
        kind = bper_pkg::KIND_KEY;
        idx  = bper_pkg::key_order(sel);
        val  = VW'(job_q.now[idx]);
      end
      SLOT_UP: begin
        kind = bper_pkg::KIND_RELY;
        val  = neg;
      end
      SLOT_DOWN: begin
        kind = bper_pkg::KIND_RELY;
        val  = pos;
      end
      SLOT_LEFT: begin
        kind = bper_pkg::KIND_RELX;
        val  = neg;
      end
      SLOT_RIGHT: begin
        kind = bper_pkg::KIND_RELX;
        val  = pos;
      end
      SLOT_BTN_R: begin
        kind = bper_pkg::KIND_RIGHT;
        val  = VW'(job_q.right);
      end
      SLOT_BTN_L: begin
        kind = bper_pkg::KIND_LEFT;
        val  = VW'(job_q.left);
      end
      SLOT_MTSYNC: kind = bper_pkg::KIND_MTSYNC;
      default:     kind = bper_pkg::KIND_SYNC;
    endcase
  end

  assign busy    = pend_q != '0;
  assign adv     = busy && (!valid_q || out_ready_i);
  assign load    = q_valid_i && (!busy || (adv && rest == '0));
  assign q_pop_o = load;

  always_comb begin
    pend_d  = pend_q;
    valid_d = valid_q;
    data_d  = data_q;
    user_d  = user_q;
    last_d  = last_q;
    if (adv) pend_d = rest;
    if (load) pend_d = pend_new;
    if (adv) begin
      valid_d = 1'b1;
      data_d  = bper_pkg::OUT_W'({val, idx});
      user_d  = kind;
      last_d  = rest == '0;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) job_q <= q_job_i;
    data_q <= data_d;
    user_q <= user_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      pend_q  <= pend_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_user_o  = user_q;
  assign out_last_o  = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(oh))
    else $error("more than one event slot selected");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !busy || rest == '0)
    else $error("new transaction loaded over pending events");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && rest == '0 |=> last_q && valid_q)
    else $error("final event of a tick not marked last");

endmodule

[hdl/button_poll_event_reporter_top.sv]
// Button poll event reporter.
// Slave stream: one transaction per poll tick, s_axis_tdata[17:0] holding the
// active-low button levels. Master stream: one transaction per event,
// tuser = event_kind, tdata = {event_value[7:0], button_index[4:0]}, tlast on
// the final event of a tick. With key reporting on, a tick that changes nothing sends no events.
// Config channel: cfg_index_i 0 = key report enable (bit 0), 1 = mouse_step
// (bits 6:0); other indexes are ignored. Write only while idle.
// The front stage classifies a tick in its accept cycle and queues a job
// (two entries); the emitter sends one event per cycle from its output
// register while m_axis_tready is high. A job passes the queue, the emitter's
// pending register and its output register before its first event goes out.
// A tick yields up to 19 events, and ticks are taken back to back while
// the queue has room.
// m_axis_tready low holds the current event; the queue fills and then
// s_axis_tready drops. Reset clears the sampled and reported button state,
// the mouse button state, the queue and the output, and restores key
// reporting on and mouse_step = 5.
module button_poll_event_reporter_top #(
  parameter int unsigned NUM_BUTTONS = bper_pkg::DEF_NUM_BUTTONS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bper_pkg::PIN_W-1:0]      s_axis_tdata,  // pin_levels[17:0], zero pad
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bper_pkg::OUT_W-1:0]      m_axis_tdata,  // button_index, event_value, zero pad
  output logic [bper_pkg::KIND_W-1:0]     m_axis_tuser,  // event_kind
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bper_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bper_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic           q_full, q_push, q_pop, q_valid;
  bper_pkg::job_t push_job, head_job;

  assign cfg_ready_o = 1'b1;

  bper_front #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_pins_i   (s_axis_tdata[bper_pkg::NUM_PINS-1:0]),
    .q_full_i    (q_full),
    .in_ready_o  (s_axis_tready),
    .q_push_o    (q_push),
    .q_job_o     (push_job)
  );

  bper_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  bper_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (head_job),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

[bench/button_event_checker.sv]
module button_event_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             tick_valid_i,
  input  logic                             tick_ready_i,
  input  logic [bper_pkg::PIN_W-1:0]       tick_data_i,
  input  logic                             evt_valid_i,
  input  logic                             evt_ready_i,
  input  logic [bper_pkg::OUT_W-1:0]       evt_data_i,
  input  logic [bper_pkg::KIND_W-1:0]      evt_user_i,
  input  logic                             evt_last_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [bper_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bper_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               events_checked_o
);

  localparam int unsigned NP = bper_pkg::NUM_PINS;
  localparam int unsigned IW = bper_pkg::IDX_W;
  localparam int unsigned VW = bper_pkg::VAL_W;

  typedef struct packed {
    bper_pkg::event_kind_e kind;
    logic [IW-1:0]         button;
    logic signed [VW-1:0]  value;
    logic                  is_last;
  } button_event_t;

  // key report order: shoulder keys ahead of select/start, volp ahead of volm
  int unsigned report_order [0:NP-1] =
    '{0, 1, 2, 3, 4, 5, 6, 7, 10, 11, 12, 13, 8, 9, 14, 16, 15, 17};

  button_event_t                 expected_events[$];
  logic                          key_report_en;
  logic [bper_pkg::STEP_W-1:0]   mouse_step;
  logic [NP-1:0]                 last_sample;
  logic [NP-1:0]                 reported;
  logic                          left_held;
  logic                          right_held;
  int                            fails;
  int                            checked;

  function automatic button_event_t make_event(input bper_pkg::event_kind_e kind,
                                               input int unsigned button,
                                               input logic [VW-1:0] value);
    button_event_t e;
    e.kind    = kind;
    e.button  = IW'(button);
    e.value   = value;
    e.is_last = 1'b0;
    return e;
  endfunction

  task automatic predict_events(input logic [NP-1:0] levels);
    logic [NP-1:0]    pressed;
    logic [VW-1:0]    up_step;
    logic [VW-1:0]    dn_step;
    logic             need;
    int unsigned      b;
    button_event_t    batch[$];
    pressed = ~levels;
    up_step = {1'b0, mouse_step};
    dn_step = -up_step;
    need    = 1'b0;
    if (pressed != last_sample) begin
      last_sample = pressed;
      if (key_report_en) begin
        foreach (report_order[i]) begin
          b = report_order[i];
          if (pressed[b] != reported[b]) begin
            reported[b] = pressed[b];
            batch.push_back(make_event(bper_pkg::KIND_KEY, b, {7'd0, pressed[b]}));
          end
        end
      end
      batch.push_back(make_event(bper_pkg::KIND_SYNC, 0, '0));
    end
    if (!key_report_en) begin
      if (pressed[0]) begin
        need = 1'b1;
        batch.push_back(make_event(bper_pkg::KIND_RELY, 0, dn_step));
      end
      if (pressed[1]) begin
        need = 1'b1;
        batch.push_back(make_event(bper_pkg::KIND_RELY, 0, up_step));
      end
      if (pressed[2]) begin
        need = 1'b1;
        batch.push_back(make_event(bper_pkg::KIND_RELX, 0, dn_step));
      end
      if (pressed[3]) begin
        need = 1'b1;
        batch.push_back(make_event(bper_pkg::KIND_RELX, 0, up_step));
      end
      if (pressed[bper_pkg::BTN_A] != right_held) begin
        right_held = pressed[bper_pkg::BTN_A];
        need = 1'b1;
      end
      if (pressed[bper_pkg::BTN_Y] != left_held) begin
        left_held = pressed[bper_pkg::BTN_Y];
        need = 1'b1;
      end
      if (need) begin
        batch.push_back(make_event(bper_pkg::KIND_RIGHT, 0, {7'd0, right_held}));
        batch.push_back(make_event(bper_pkg::KIND_LEFT, 0, {7'd0, left_held}));
        batch.push_back(make_event(bper_pkg::KIND_MTSYNC, 0, '0));
        batch.push_back(make_event(bper_pkg::KIND_SYNC, 0, '0));
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].is_last = 1'b1;
    foreach (batch[i]) expected_events.push_back(batch[i]);
  endtask

  task automatic check_event();
    button_event_t got;
    button_event_t want;
    got.kind    = bper_pkg::event_kind_e'(evt_user_i);
    got.button  = evt_data_i[IW-1:0];
    got.value   = evt_data_i[IW+VW-1:IW];
    got.is_last = evt_last_i;
    checked++;
    if (expected_events.size() == 0) begin
      fails++;
      $display("%0t: unexpected event: kind %0d index %0d value %0d last %0b", $time,
               got.kind, got.button, got.value, got.is_last);
    end else begin
      want = expected_events.pop_front();
      if (got.kind !== want.kind || got.button !== want.button ||
          got.value !== want.value || got.is_last !== want.is_last) begin
        fails++;
        $display("%0t: event mismatch: expected kind %0d index %0d value %0d last %0b",
                 $time, want.kind, want.button, want.value, want.is_last);
        $display("%0t:                 actual   kind %0d index %0d value %0d last %0b",
                 $time, got.kind, got.button, got.value, got.is_last);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_events.delete();
      key_report_en    = bper_pkg::KEY_MODE_RST;
      mouse_step       = bper_pkg::MOUSE_STEP_RST;
      last_sample      = '0;
      reported         = '0;
      left_held        = 1'b0;
      right_held       = 1'b0;
      fails            = 0;
      checked          = 0;
      fail_count_o     <= 0;
      pending_o        <= 0;
      events_checked_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          bper_pkg::REG_KEY_MODE:   key_report_en = cfg_data_i[0];
          bper_pkg::REG_MOUSE_STEP: mouse_step = cfg_data_i[bper_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
      if (evt_valid_i && evt_ready_i) check_event();
      if (tick_valid_i && tick_ready_i) predict_events(tick_data_i[NP-1:0]);
      fail_count_o     <= fails;
      pending_o        <= expected_events.size();
      events_checked_o <= checked;
    end
  end

endmodule

[bench/tb_button_poll_event_reporter_top.sv]
module tb_button_poll_event_reporter_top;

  localparam int unsigned NP  = bper_pkg::NUM_PINS;
  localparam int unsigned PW  = bper_pkg::PIN_W;
  localparam int unsigned OW  = bper_pkg::OUT_W;
  localparam int unsigned KW  = bper_pkg::KIND_W;
  localparam int unsigned CIW = bper_pkg::CFG_IDX_W;
  localparam int unsigned CDW = bper_pkg::CFG_DATA_W;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           s_axis_tvalid = 1'b0;
  logic           s_axis_tready;
  logic [PW-1:0]  s_axis_tdata = '0;
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  logic [OW-1:0]  m_axis_tdata;
  logic [KW-1:0]  m_axis_tuser;
  logic           m_axis_tlast;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  logic [CIW-1:0] cfg_index_i = '0;
  logic [CDW-1:0] cfg_data_i = '0;

  int fail_count;
  int pending;
  int events_checked;

  int            hold_req = 0;
  bit            hold_active = 1'b0;
  bit            no_idle = 1'b0;
  int            ticks_sent = 0;
  int            cfg_writes = 0;
  logic [NP-1:0] levels;

  button_poll_event_reporter_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  button_event_checker u_event_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_valid_i     (s_axis_tvalid),
    .tick_ready_i     (s_axis_tready),
    .tick_data_i      (s_axis_tdata),
    .evt_valid_i      (m_axis_tvalid),
    .evt_ready_i      (m_axis_tready),
    .evt_data_i       (m_axis_tdata),
    .evt_user_i       (m_axis_tuser),
    .evt_last_i       (m_axis_tlast),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .events_checked_o (events_checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #10000000;
    $display("tb_button_poll_event_reporter_top failed");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int sender_gap();
    if (no_idle || $urandom_range(0, 99) < 55) return 0;
    return gap_len();
  endfunction

  // mostly small edits of the last tick, biased toward the mouse keys
  function automatic logic [NP-1:0] next_levels(input logic [NP-1:0] cur);
    logic [NP-1:0] v;
    int            r;
    int            k;
    v = cur;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      repeat ($urandom_range(1, 3)) begin
        k = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, NP-1);
        v[k] = ~v[k];
      end
    end else if (r < 7) begin
      v = cur;
    end else if (r < 9) begin
      v = NP'($urandom);
    end else begin
      v = $urandom_range(0, 1) ? '1 : '0;
    end
    return v;
  endfunction

  task automatic send_tick(input logic [NP-1:0] pins, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= PW'(pins);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ticks_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // index 2 and 3 are unused and must be ignored
  task automatic set_config(input logic [CDW-1:0] mode_data,
                            input logic [CDW-1:0] step_data,
                            input bit poke_unused);
    int n;
    for (n = 0; n < (poke_unused ? 4 : 2); n++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CIW'(n);
      if (n == bper_pkg::REG_KEY_MODE) cfg_data_i <= mode_data;
      else if (n == bper_pkg::REG_MOUSE_STEP) cfg_data_i <= step_data;
      else cfg_data_i <= CDW'($urandom);
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      cfg_writes++;
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int len;
    bit lvl;
    @(posedge clk_i);
    forever begin
      if (hold_req > 0) begin
        len = hold_req;
        hold_req = 0;
        lvl = 1'b0;
        hold_active = 1'b1;
      end else if (!no_idle && $urandom_range(0, 2) == 0) begin
        len = gap_len();
        lvl = 1'b0;
      end else begin
        len = $urandom_range(1, 6);
        lvl = 1'b1;
      end
      m_axis_tready <= lvl;
      repeat (len) @(posedge clk_i);
      hold_active = 1'b0;
    end
  end

  initial begin
    int p;
    int i;
    levels = '1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // keypad mode after reset
    send_tick('1, sender_gap());
    send_tick('0, sender_gap());
    send_tick('1, sender_gap());
    send_tick(~NP'((1 << 15) | (1 << 16)), sender_gap());
    send_tick(~NP'((1 << 8) | (1 << 9) | (1 << 10)), sender_gap());
    send_tick(~NP'((1 << 8) | (1 << 9) | (1 << 10)), sender_gap());
    send_tick(~NP'(1 << 17), sender_gap());
    send_tick(NP'(18'h2AAAA), sender_gap());
    send_tick(NP'(18'h15555), sender_gap());

    // output held off while full ticks keep coming
    drain();
    hold_req = 200;
    while (!hold_active) @(posedge clk_i);
    for (i = 0; i < 8; i++) send_tick(i[0] ? '1 : '0, 0);
    drain();

    // mouse mode, zero step
    set_config(8'hFE, 8'h80, 1'b1);
    send_tick(~NP'(18'h00001), sender_gap());
    send_tick(~NP'(18'h00001), sender_gap());
    send_tick(~NP'(18'h0001F), sender_gap());
    send_tick(~NP'(18'h00090), sender_gap());
    send_tick('1, sender_gap());
    send_tick(~NP'(18'h3FF00), sender_gap());
    drain();
    set_config(8'h00, 8'hFF, 1'b0);
    send_tick(~NP'(18'h0000F), sender_gap());
    drain();
    // back to keypad: the stale report catches up
    set_config(8'h03, 8'h05, 1'b1);
    send_tick('1, sender_gap());
    levels = '1;

    for (p = 0; p < 6; p++) begin
      drain();
      no_idle = (p == 3);
      case (p)
        0: set_config(8'h01, CDW'($urandom), 1'b0);
        1: set_config(8'h00, 8'h01, 1'b0);
        2: set_config(8'h00, 8'h7F, 1'b0);
        3: set_config(8'h01, 8'h05, 1'b1);
        4: set_config(8'h00, 8'h00, 1'b0);
        default: set_config(8'h00, CDW'($urandom), 1'b1);
      endcase
      for (i = 0; i < 16; i++) begin
        levels = next_levels(levels);
        send_tick(levels, sender_gap());
      end
    end
    no_idle = 1'b0;
    drain();

    $display("run covered %0d poll ticks, %0d events checked, %0d register writes",
             ticks_sent, events_checked, cfg_writes);
    $display("keypad and mouse modes, steps 0 to 127, back-pressure and stale reports");
    if (fail_count == 0) begin
      $display("tb_button_poll_event_reporter_top passed");
    end else begin
      $display("tb_button_poll_event_reporter_top failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/bper_pkg.sv
hdl/bper_front.sv
hdl/bper_queue.sv
hdl/bper_emit.sv
hdl/button_poll_event_reporter_top.sv
bench/button_event_checker.sv
bench/tb_button_poll_event_reporter_top.sv
